>>> rtl/core/es2utc_pkg.sv
// ----------------------------------------------------------------------------
// es2utc_pkg
// Constants for the epoch seconds to calendar conversion: day counts,
// reciprocal multipliers for the constant divisions and the month tables.
// ----------------------------------------------------------------------------
package es2utc_pkg;

  localparam int unsigned DAYS_PER_YEAR        = 365;
  localparam int unsigned DAYS_PER_QUAD        = 4 * 365 + 1;
  localparam int unsigned QUAD_YEAR2_START     = 365 * 2;
  localparam int unsigned QUAD_YEAR3_START     = 365 * 3 + 1;
  localparam int unsigned EPOCH_WEEKDAY        = 4;
  localparam int unsigned DAYS_PER_WEEK        = 7;
  localparam int unsigned YEAR_OFFSET          = 70;
  localparam logic [31:0] FIRST_INVALID_SECOND = 32'd4102444800;

  // seconds per day is 128 * 675; the low 7 bits pass straight through
  localparam int unsigned DAY_DIVISOR = 675;
  localparam int unsigned SEC_PER_MIN = 60;
  localparam int unsigned MIN_PER_HOUR = 60;

  // floor(2^k / d) with 2^k above the dividend: estimate is q or q - 1
  localparam int unsigned DAY_RECIP_SHIFT  = 25;
  localparam logic [15:0] DAY_RECIP        = 16'((64'd1 << DAY_RECIP_SHIFT) / DAY_DIVISOR);
  localparam int unsigned MIN_RECIP_SHIFT  = 17;
  localparam logic [11:0] MIN_RECIP        = 12'((64'd1 << MIN_RECIP_SHIFT) / SEC_PER_MIN);
  localparam int unsigned QUAD_RECIP_SHIFT = 16;
  localparam logic [5:0]  QUAD_RECIP       = 6'((64'd1 << QUAD_RECIP_SHIFT) / DAYS_PER_QUAD);
  localparam int unsigned WEEK_RECIP_SHIFT = 17;
  localparam logic [14:0] WEEK_RECIP       = 15'((64'd1 << WEEK_RECIP_SHIFT) / DAYS_PER_WEEK);
  localparam int unsigned HOUR_RECIP_SHIFT = 11;
  localparam logic [5:0]  HOUR_RECIP       = 6'((64'd1 << HOUR_RECIP_SHIFT) / MIN_PER_HOUR);

  typedef logic [8:0] yday_t;

  localparam int unsigned MONTHS = 12;

  // first day of each month, normal row then leap row
  localparam yday_t MONTH_START [0:1][0:MONTHS-1] = '{
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334},
    '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335}
  };

endpackage

>>> rtl/core/epoch_seconds_to_utc_calendar_unit.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar_unit
// Converts seconds since 1970-01-01 UTC into broken-down calendar fields.
// ----------------------------------------------------------------------------
// Usage:
//   The epoch channel (epoch_valid / epoch_ready / epoch_seconds) takes one
//   unsigned 32-bit timestamp per item. The calendar channel (calendar_valid /
//   calendar_ready and the field ports) returns one result item per input,
//   in order.
//   An accepted item passes through all six stages to calendar_valid. Throughput
//   is one item per cycle while the receiver takes results; each stage holds
//   multipliers by constant reciprocals, the compare-and-correct steps that
//   follow them, or both, and the month table compare sits in the last stage.
//   Each stage has its own valid bit and advances when it is empty or the
//   stage after it moves, so bubbles close up. When the receiver stalls, the
//   result holds on the output and the stages behind it fill; epoch_ready
//   falls only when all six stages hold items.
//   Years follow the every-fourth-year rule; beyond_range flags inputs from
//   2100-01-01 onward, which are still converted by that rule.
//   Reset empties the pipeline; payload registers are not cleared.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_calendar_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        epoch_valid,
  output logic        epoch_ready,
  input  logic [31:0] epoch_seconds,
  output logic        calendar_valid,
  input  logic        calendar_ready,
  output logic [5:0]  second_of_minute,
  output logic [5:0]  minute_of_hour,
  output logic [4:0]  hour_of_day,
  output logic [2:0]  weekday,
  output logic [7:0]  year_since_1900,
  output es2utc_pkg::yday_t day_of_year,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month,
  output logic        beyond_range
);

  import es2utc_pkg::*;

  localparam int STAGES = 6;

  logic [STAGES:1] stage_valid;
  logic [STAGES:1] stage_en;

  always_comb begin
    stage_en[STAGES] = !stage_valid[STAGES] || calendar_ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      stage_en[k] = !stage_valid[k] || stage_en[k + 1];
    end
  end

  assign epoch_ready    = stage_en[1];
  assign calendar_valid = stage_valid[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_en[1]) begin
        stage_valid[1] <= epoch_valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (stage_en[k]) begin
          stage_valid[k] <= stage_valid[k - 1];
        end
      end
    end
  end

  // stage 1: day estimate product on seconds / 128
  logic [31:0] s1_time;
  logic [40:0] s1_day_prod;
  logic        s1_beyond;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s1_time     <= epoch_seconds;
      s1_day_prod <= epoch_seconds[31:7] * DAY_RECIP;
      s1_beyond   <= (epoch_seconds >= FIRST_INVALID_SECOND);
    end
  end

  // stage 2: correct day count, second of day
  logic [15:0] s2_days;
  logic [16:0] s2_sod;
  logic        s2_beyond;
  logic [15:0] day_est;
  logic [24:0] day_diff;
  logic [10:0] day_rem;
  logic [15:0] days_next;
  logic [9:0]  day_rem_fix;

  always_comb begin
    day_est  = s1_day_prod[40:DAY_RECIP_SHIFT];
    day_diff = s1_time[31:7] - 25'(day_est * 25'(DAY_DIVISOR));
    day_rem  = day_diff[10:0];
    if (day_rem >= 11'(DAY_DIVISOR)) begin
      days_next   = day_est + 16'd1;
      day_rem_fix = 10'(day_rem - 11'(DAY_DIVISOR));
    end else begin
      days_next   = day_est;
      day_rem_fix = day_rem[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      s2_days   <= days_next;
      s2_sod    <= {day_rem_fix, s1_time[6:0]};
      s2_beyond <= s1_beyond;
    end
  end

  // stage 3: products for minutes, four-year groups and weekday
  logic [16:0] s3_sod;
  logic [15:0] s3_days;
  logic [16:0] s3_days_wk;
  logic [28:0] s3_min_prod;
  logic [21:0] s3_quad_prod;
  logic [31:0] s3_week_prod;
  logic        s3_beyond;
  logic [16:0] days_wk;

  assign days_wk = {1'b0, s2_days} + 17'(EPOCH_WEEKDAY);

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s3_sod       <= s2_sod;
      s3_days      <= s2_days;
      s3_days_wk   <= days_wk;
      s3_min_prod  <= s2_sod * MIN_RECIP;
      s3_quad_prod <= s2_days * QUAD_RECIP;
      s3_week_prod <= days_wk * WEEK_RECIP;
      s3_beyond    <= s2_beyond;
    end
  end

  // stage 4: correct minutes, seconds, quad, day in quad, weekday
  logic [10:0] s4_mins;
  logic [5:0]  s4_sec;
  logic [5:0]  s4_quad;
  logic [10:0] s4_qrem;
  logic [2:0]  s4_wday;
  logic        s4_beyond;
  logic [11:0] min_est;
  logic [16:0] sec_diff;
  logic [6:0]  sec_raw;
  logic [10:0] mins_next;
  logic [5:0]  sec_next;
  logic [5:0]  quad_est;
  logic [15:0] quad_diff;
  logic [11:0] qrem_raw;
  logic [5:0]  quad_next;
  logic [10:0] qrem_next;
  logic [14:0] week_est;
  logic [16:0] week_diff;
  logic [3:0]  wday_raw;
  logic [2:0]  wday_next;

  always_comb begin
    min_est  = s3_min_prod[28:MIN_RECIP_SHIFT];
    sec_diff = s3_sod - 17'(min_est * 17'(SEC_PER_MIN));
    sec_raw  = sec_diff[6:0];
    if (sec_raw >= 7'(SEC_PER_MIN)) begin
      mins_next = 11'(min_est + 12'd1);
      sec_next  = 6'(sec_raw - 7'(SEC_PER_MIN));
    end else begin
      mins_next = min_est[10:0];
      sec_next  = sec_raw[5:0];
    end

    quad_est  = s3_quad_prod[21:QUAD_RECIP_SHIFT];
    quad_diff = s3_days - 16'(quad_est * 16'(DAYS_PER_QUAD));
    qrem_raw  = quad_diff[11:0];
    if (qrem_raw >= 12'(DAYS_PER_QUAD)) begin
      quad_next = quad_est + 6'd1;
      qrem_next = 11'(qrem_raw - 12'(DAYS_PER_QUAD));
    end else begin
      quad_next = quad_est;
      qrem_next = qrem_raw[10:0];
    end

    week_est  = s3_week_prod[31:WEEK_RECIP_SHIFT];
    week_diff = s3_days_wk - 17'(week_est * 17'(DAYS_PER_WEEK));
    wday_raw  = week_diff[3:0];
    if (wday_raw >= 4'(DAYS_PER_WEEK)) begin
      wday_next = 3'(wday_raw - 4'(DAYS_PER_WEEK));
    end else begin
      wday_next = wday_raw[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      s4_mins   <= mins_next;
      s4_sec    <= sec_next;
      s4_quad   <= quad_next;
      s4_qrem   <= qrem_next;
      s4_wday   <= wday_next;
      s4_beyond <= s3_beyond;
    end
  end

  // stage 5: hour product, year within the four-year group
  logic [16:0] s5_hour_prod;
  logic [10:0] s5_mins;
  logic [5:0]  s5_sec;
  logic [2:0]  s5_wday;
  logic [7:0]  s5_year;
  yday_t       s5_yday;
  logic        s5_leap;
  logic        s5_beyond;
  logic [1:0]  year_in_quad;
  yday_t       yday_next;
  logic        leap_next;

  always_comb begin
    leap_next = 1'b0;
    if (s4_qrem >= 11'(QUAD_YEAR3_START)) begin
      year_in_quad = 2'd3;
      yday_next    = 9'(s4_qrem - 11'(QUAD_YEAR3_START));
    end else if (s4_qrem >= 11'(QUAD_YEAR2_START)) begin
      year_in_quad = 2'd2;
      yday_next    = 9'(s4_qrem - 11'(QUAD_YEAR2_START));
      leap_next    = 1'b1;
    end else if (s4_qrem >= 11'(DAYS_PER_YEAR)) begin
      year_in_quad = 2'd1;
      yday_next    = 9'(s4_qrem - 11'(DAYS_PER_YEAR));
    end else begin
      year_in_quad = 2'd0;
      yday_next    = s4_qrem[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      s5_hour_prod <= s4_mins * HOUR_RECIP;
      s5_mins      <= s4_mins;
      s5_sec       <= s4_sec;
      s5_wday      <= s4_wday;
      s5_year      <= {s4_quad, year_in_quad} + 8'(YEAR_OFFSET);
      s5_yday      <= yday_next;
      s5_leap      <= leap_next;
      s5_beyond    <= s4_beyond;
    end
  end

  // stage 6: hour and minute, month lookup, output register
  logic [5:0]  hour_est;
  logic [10:0] min_diff;
  logic [6:0]  min_raw;
  logic [4:0]  hour_next;
  logic [5:0]  minute_next;
  logic [3:0]  month_next;
  yday_t       month_base;
  logic [4:0]  mday_next;

  always_comb begin
    hour_est = s5_hour_prod[16:HOUR_RECIP_SHIFT];
    min_diff = s5_mins - 11'(hour_est * 11'(MIN_PER_HOUR));
    min_raw  = min_diff[6:0];
    if (min_raw >= 7'(MIN_PER_HOUR)) begin
      hour_next   = 5'(hour_est + 6'd1);
      minute_next = 6'(min_raw - 7'(MIN_PER_HOUR));
    end else begin
      hour_next   = hour_est[4:0];
      minute_next = min_raw[5:0];
    end

    // table rows rise, so the last start not above the day wins
    month_next = 4'd0;
    month_base = MONTH_START[s5_leap][0];
    for (int k = 1; k < MONTHS; k++) begin
      if (MONTH_START[s5_leap][k] <= s5_yday) begin
        month_next = 4'(k);
        month_base = MONTH_START[s5_leap][k];
      end
    end
    mday_next = 5'(s5_yday + 9'd1 - month_base);
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      second_of_minute <= s5_sec;
      minute_of_hour   <= minute_next;
      hour_of_day      <= hour_next;
      weekday          <= s5_wday;
      year_since_1900  <= s5_year;
      day_of_year      <= s5_yday;
      month_index      <= month_next;
      day_of_month     <= mday_next;
      beyond_range     <= s5_beyond;
    end
  end

  // an accepted item always lands in the first stage
  assert property (@(posedge clk) disable iff (rst)
    epoch_valid && epoch_ready |=> stage_valid[1])
    else $error("accepted item not captured in first stage");

  // a stalled output stage keeps a full stage 5 behind it stalled too
  assert property (@(posedge clk) disable iff (rst)
    calendar_valid && !calendar_ready && stage_valid[5] |=> stage_valid[6] && stage_valid[5])
    else $error("item lost behind stalled output");

  // reciprocal corrections leave remainders in range
  assert property (@(posedge clk) disable iff (rst)
    stage_valid[2] |-> s2_sod < 17'd86400 && s2_days < 16'd49711)
    else $error("day split out of range");

  assert property (@(posedge clk) disable iff (rst)
    stage_valid[4] |-> s4_mins < 11'd1440 && s4_sec < 6'd60 &&
                       s4_qrem < 11'(DAYS_PER_QUAD) && s4_wday < 3'(DAYS_PER_WEEK))
    else $error("minute, quad or weekday remainder out of range");

  assert property (@(posedge clk) disable iff (rst)
    calendar_valid |-> month_index < 4'(MONTHS) && day_of_month != 5'd0 &&
                       hour_of_day < 5'd24 && minute_of_hour < 6'd60)
    else $error("calendar result out of range");

endmodule
